[design/fmbssc_pkg.sv]
// Shared types, widths and codes for the fan mode button soft start controller.
package fmbssc_pkg;

   // Full scale of the soft start ramp, the numerator constant of each ramp step.
   localparam int DUTY_FULL_SCALE = 1023;

   // Field widths.
   localparam int CNT_W      = 16;
   localparam int STEP_W     = 8;
   localparam int DUTY_W     = 10;
   localparam int MODE_W     = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Divider widths follow from the full scale value.
   localparam int FS_W   = $clog2(DUTY_FULL_SCALE + 1);
   localparam int PROD_W = STEP_W + FS_W;
   localparam int ITER_W = $clog2(FS_W);

   localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
   localparam logic [DUTY_W-1:0] DUTY_MAX = {DUTY_W{1'b1}};

   // Mode codes.
   localparam logic [MODE_W-1:0] MODE_UNSET = 3'd0;
   localparam logic [MODE_W-1:0] MODE_RAMP  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_P1    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_P2    = 3'd3;
   localparam logic [MODE_W-1:0] MODE_P3    = 3'd4;
   localparam logic [MODE_W-1:0] MODE_P4    = 3'd5;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_MS      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_INTERVAL_MS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_STEPS       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESET_DUTY_ONE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESET_DUTY_TWO  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESET_DUTY_THREE = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESET_DUTY_FOUR = 3'd6;

   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [STEP_W-1:0] step_type;
   typedef logic [DUTY_W-1:0] duty_type;
   typedef logic [MODE_W-1:0] mode_type;

   // Current configuration register values.
   typedef struct packed {
      cnt_type  debounce_ms;
      cnt_type  ramp_interval_ms;
      step_type ramp_steps;
      duty_type preset_duty_one;
      duty_type preset_duty_two;
      duty_type preset_duty_three;
      duty_type preset_duty_four;
   } cfg_type;

   // Request to the ramp divider.
   typedef struct packed {
      logic     start;
      step_type step;
      step_type steps;
   } div_req_type;

   // Answer of the ramp divider.
   typedef struct packed {
      logic              done;
      logic [FS_W-1:0]   quotient;
   } div_rsp_type;

endpackage

[design/fmbssc_req_if.sv]
// Tick input channel: one sampled button level per transaction.
interface fmbssc_req_if;
   logic valid;
   logic ready;
   logic button_level;

   modport source (output valid, output button_level, input ready);
   modport sink   (input valid, input button_level, output ready);
endinterface

[design/fmbssc_rsp_if.sv]
// Result channel: duty, duty change flag and mode for each tick.
interface fmbssc_rsp_if;
   import fmbssc_pkg::*;

   logic     valid;
   logic     ready;
   duty_type duty;
   logic     duty_changed;
   mode_type mode;

   modport source (output valid, output duty, output duty_changed, output mode, input ready);
   modport sink   (input valid, input duty, input duty_changed, input mode, output ready);
endinterface

[design/fmbssc_csr.sv]
// Configuration registers with their reset values.
module fmbssc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [fmbssc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fmbssc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output fmbssc_pkg::cfg_type                 cfg
);
   import fmbssc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the register index; unknown indexes are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_DEBOUNCE_MS:       cfg_in.debounce_ms       = csr_wdata;
            CSR_RAMP_INTERVAL_MS:  cfg_in.ramp_interval_ms  = csr_wdata;
            CSR_RAMP_STEPS:        cfg_in.ramp_steps        = csr_wdata[STEP_W-1:0];
            CSR_PRESET_DUTY_ONE:   cfg_in.preset_duty_one   = csr_wdata[DUTY_W-1:0];
            CSR_PRESET_DUTY_TWO:   cfg_in.preset_duty_two   = csr_wdata[DUTY_W-1:0];
            CSR_PRESET_DUTY_THREE: cfg_in.preset_duty_three = csr_wdata[DUTY_W-1:0];
            CSR_PRESET_DUTY_FOUR:  cfg_in.preset_duty_four  = csr_wdata[DUTY_W-1:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms       <= 16'd500;
         cfg_ff.ramp_interval_ms  <= 16'd1000;
         cfg_ff.ramp_steps        <= 8'd60;
         cfg_ff.preset_duty_one   <= 10'd255;
         cfg_ff.preset_duty_two   <= 10'd511;
         cfg_ff.preset_duty_three <= 10'd767;
         cfg_ff.preset_duty_four  <= 10'd1023;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[design/fmbssc_div.sv]
// Serial restoring divider for the soft start duty, one quotient bit per cycle.
module fmbssc_div (
   input  logic                     clock,
   input  logic                     reset,
   input  fmbssc_pkg::div_req_type  div_req,
   output fmbssc_pkg::div_rsp_type  div_rsp
);
   import fmbssc_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [ITER_W-1:0]   cnt_ff, cnt_in;
   logic [STEP_W-1:0]   rem_ff, rem_in;
   logic [FS_W-1:0]     quo_ff, quo_in;
   logic [STEP_W-1:0]   dvs_ff, dvs_in;

   logic [PROD_W-1:0]   prod;
   logic [STEP_W:0]     trial;
   logic [STEP_W:0]     diff;
   logic                fits;

   // The dividend is step times full scale. Since step is below the divisor,
   // its upper bits are already a valid partial remainder and only the low
   // FS_W bits need to be shifted through.
   assign prod  = PROD_W'(div_req.step) * PROD_W'(DUTY_FULL_SCALE);
   assign trial = {rem_ff, quo_ff[FS_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = (trial >= {1'b0, dvs_ff});

   // Load on start, then one trial subtraction per cycle.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = ITER_W'(FS_W - 1);
         rem_in  = prod[PROD_W-1:FS_W];
         quo_in  = prod[FS_W-1:0];
         dvs_in  = div_req.steps;
      end else if (busy_ff) begin
         rem_in = fits ? diff[STEP_W-1:0] : trial[STEP_W-1:0];
         quo_in = {quo_ff[FS_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

`ifndef NO_ASSERTIONS
   // A new division is never started while one is still running.
   assert property (@(posedge clock) disable iff (reset) div_req.start |-> !busy_ff)
      else $error("divider started while busy");
   // Completion is a single cycle pulse.
   assert property (@(posedge clock) disable iff (reset) done_ff |=> !done_ff)
      else $error("divider done held longer than one cycle");
   // The divider is idle once it reports completion.
   assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff)
      else $error("divider still busy after completion");
`endif

endmodule

[design/fan_mode_button_soft_start_controller_core.sv]
// Top level of the fan mode button soft start controller.
//
// Usage:
// - req_chan carries one transaction per millisecond tick with the sampled
//   button level (0 pressed, 1 released); valid/ready handshake.
// - rsp_chan returns exactly one transaction per tick: duty count, a flag
//   that the duty was written on that tick, and the mode code.
// - csr_we/csr_index/csr_wdata write the configuration registers; write them
//   only while no tick is in flight.
// Sequencing:
// - A tick without a ramp step goes from the idle state to the publish state,
//   which copies it into the result register once that is free. A tick that
//   takes a ramp step first runs the serial divider, which computes FS_W quotient
//   bits and pulses done. The next tick is accepted once the sequencer is idle.
// - req_chan.ready is high only between ticks; a result waiting in the
//   output register does not block acceptance of the next tick.
// Reset: synchronous, active high. Mode returns to unset, the button is taken
// as released, counters and duty clear and registers get their defaults.
// Stall: while rsp_chan.ready is low the result register holds; a following
// tick is finished internally and waits until the register is free.
module fan_mode_button_soft_start_controller_core (
   input  logic                                clock,
   input  logic                                reset,
   fmbssc_req_if.sink                          req_chan,
   fmbssc_rsp_if.source                        rsp_chan,
   input  logic                                csr_we,
   input  logic [fmbssc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fmbssc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import fmbssc_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_DIV, S_OUT} state_type;

   cfg_type     cfg;
   div_req_type div_req;
   div_rsp_type div_rsp;

   state_type   state_ff, state_in;
   mode_type    mode_ff, mode_in;
   logic        acc_ff, acc_in;
   cnt_type     deb_ff, deb_in;
   cnt_type     ramp_ff, ramp_in;
   step_type    step_ff, step_in;
   duty_type    duty_ff, duty_in;
   logic        changed_ff, changed_in;

   logic        rsp_valid_ff, rsp_valid_in;
   duty_type    rsp_duty_ff, rsp_duty_in;
   logic        rsp_changed_ff, rsp_changed_in;
   mode_type    rsp_mode_ff, rsp_mode_in;

   cnt_type     deb_inc, ramp_inc;
   step_type    step_inc;
   logic        t_acc, t_changed, t_div;
   mode_type    t_mode;
   duty_type    t_duty;
   cnt_type     t_deb, t_ramp;
   step_type    t_step;
   duty_type    div_duty;

   fmbssc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   fmbssc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Saturating elapsed counters and the next ramp step.
   assign deb_inc  = (deb_ff == CNT_MAX) ? deb_ff : deb_ff + 1'b1;
   assign ramp_inc = (ramp_ff == CNT_MAX) ? ramp_ff : ramp_ff + 1'b1;
   assign step_inc = step_ff + 1'b1;

   // Quotient clipped to the duty range.
   assign div_duty = (div_rsp.quotient > FS_W'(DUTY_MAX)) ? DUTY_MAX
                                                           : DUTY_W'(div_rsp.quotient);

   // One tick: debounce and mode advance, then the ramp decision.
   always_comb begin
      t_acc     = acc_ff;
      t_deb     = deb_inc;
      t_ramp    = ramp_inc;
      t_mode    = mode_ff;
      t_duty    = duty_ff;
      t_step    = step_ff;
      t_changed = 1'b0;
      t_div     = 1'b0;
      if (req_chan.button_level != acc_ff && deb_inc >= cfg.debounce_ms) begin
         t_acc = req_chan.button_level;
         t_deb = '0;
         if (!req_chan.button_level) begin
            case (mode_ff) inside
               MODE_UNSET: t_mode = MODE_RAMP;
               MODE_RAMP, MODE_P4: begin
                  t_mode    = MODE_P1;
                  t_duty    = cfg.preset_duty_one;
                  t_changed = 1'b1;
               end
               MODE_P1: begin
                  t_mode    = MODE_P2;
                  t_duty    = cfg.preset_duty_two;
                  t_changed = 1'b1;
               end
               MODE_P2: begin
                  t_mode    = MODE_P3;
                  t_duty    = cfg.preset_duty_three;
                  t_changed = 1'b1;
               end
               MODE_P3: begin
                  t_mode    = MODE_P4;
                  t_duty    = cfg.preset_duty_four;
                  t_changed = 1'b1;
               end
               default: t_mode = mode_ff;
            endcase
         end
      end
      if (t_mode == MODE_RAMP && ramp_inc >= cfg.ramp_interval_ms) begin
         t_ramp = '0;
         t_step = step_inc;
         if (step_inc >= cfg.ramp_steps) begin
            t_mode    = MODE_P4;
            t_duty    = cfg.preset_duty_four;
            t_changed = 1'b1;
         end else begin
            t_div = 1'b1;
         end
      end
   end

   // Sequencer: accept a tick, run the divider if needed, then publish.
   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      acc_in         = acc_ff;
      deb_in         = deb_ff;
      ramp_in        = ramp_ff;
      step_in        = step_ff;
      duty_in        = duty_ff;
      changed_in     = changed_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_duty_in    = rsp_duty_ff;
      rsp_changed_in = rsp_changed_ff;
      rsp_mode_in    = rsp_mode_ff;
      div_req.start  = 1'b0;
      div_req.step   = t_step;
      div_req.steps  = cfg.ramp_steps;
      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               mode_in       = t_mode;
               acc_in        = t_acc;
               deb_in        = t_deb;
               ramp_in       = t_ramp;
               step_in       = t_step;
               duty_in       = t_duty;
               changed_in    = t_changed || t_div;
               div_req.start = t_div;
               state_in      = t_div ? S_DIV : S_OUT;
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               duty_in  = div_duty;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_duty_in    = duty_ff;
               rsp_changed_in = changed_ff;
               rsp_mode_in    = mode_ff;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= MODE_UNSET;
         acc_ff       <= 1'b1;
         deb_ff       <= '0;
         ramp_ff      <= '0;
         step_ff      <= '0;
         duty_ff      <= '0;
         changed_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         acc_ff       <= acc_in;
         deb_ff       <= deb_in;
         ramp_ff      <= ramp_in;
         step_ff      <= step_in;
         duty_ff      <= duty_in;
         changed_ff   <= changed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_duty_ff    <= rsp_duty_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_mode_ff    <= rsp_mode_in;
   end

   assign req_chan.ready        = (state_ff == S_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.duty         = rsp_duty_ff;
   assign rsp_chan.duty_changed = rsp_changed_ff;
   assign rsp_chan.mode         = rsp_mode_ff;

`ifndef NO_ASSERTIONS
   // The divider only finishes while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset) div_rsp.done |-> state_ff == S_DIV)
      else $error("divider finished outside the divide state");
   // An accepted transaction always leaves the idle state on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> state_ff != S_IDLE)
      else $error("sequencer stayed idle after accepting a tick");
   // A duty write never comes with the unset mode.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.duty_changed) |-> rsp_chan.mode != MODE_UNSET)
      else $error("duty written while mode is unset");
`endif

endmodule
